@@ rtl/core/pulse_train_sync_generator_assert.svh @@
`ifndef PULSE_TRAIN_SYNC_GENERATOR_ASSERT_SVH
`define PULSE_TRAIN_SYNC_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pts_pkg.sv @@
package pts_pkg;

    localparam int TIME_BITS_DEFAULT = 20;
    localparam int STEP_BITS         = 16;
    localparam int PULSE_BITS        = 8;
    localparam int APB_DATA_BITS     = 32;
    localparam int APB_ADDR_BITS     = 5;

    localparam int HIGH_BASE_RESET   = 1100;
    localparam int HIGH_STEP_RESET   = 50;
    localparam int LOW_RESET         = 500;
    localparam int PULSE_COUNT_RESET = 17;
    localparam int GAP_RESET         = 3000;
    localparam int SYNC_RESET        = 50;

    typedef enum logic [2:0] {
        REG_HIGH_BASE   = 3'd0,
        REG_HIGH_STEP   = 3'd1,
        REG_LOW         = 3'd2,
        REG_PULSE_COUNT = 3'd3,
        REG_GAP         = 3'd4,
        REG_SYNC        = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic valid;
        logic enable_press;
        logic mode_press;
    } step_t;

endpackage

@@ rtl/core/pulse_train_sync_generator.sv @@
// Pulse train and sync generator. Each request is one microsecond tick carrying the
// enable and mode button press flags; every tick yields one result with the wave and
// sync levels and the mode flag. One request is taken per clock unless the input is
// stalled; it passes through the input register and then the sequencer, whose phase,
// tick counter and pulse-length multiply-add are combinational and load the result
// register. A stalled result holds the sequencer; the input register takes one more
// request and then stalls the input. Timing registers sit on an APB port at byte
// addresses 0x00 to 0x14 and should be written only while no request is in flight.
module pulse_train_sync_generator
    import pts_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     enable_press,
    input  logic                     mode_press,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     wave_level,
    output logic                     sync_level,
    output logic                     mode_flag
);

    logic [TIME_BITS-1:0]  high_base_time;
    logic [STEP_BITS-1:0]  high_step_time;
    logic [TIME_BITS-1:0]  low_time;
    logic [PULSE_BITS-1:0] pulse_count;
    logic [TIME_BITS-1:0]  gap_time;
    logic [TIME_BITS-1:0]  sync_time;
    logic                  in_valid_reg;
    logic                  enable_press_reg;
    logic                  mode_press_reg;
    step_t                 step;
    logic                  step_stall;

    pts_cfg_regs #(
        .TIME_BITS (TIME_BITS)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .high_base_time (high_base_time),
        .high_step_time (high_step_time),
        .low_time       (low_time),
        .pulse_count    (pulse_count),
        .gap_time       (gap_time),
        .sync_time      (sync_time)
    );

    assign in_stall = in_valid_reg && step_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            enable_press_reg <= 1'b0;
            mode_press_reg   <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg     <= in_valid;
            enable_press_reg <= enable_press;
            mode_press_reg   <= mode_press;
        end
    end

    assign step.valid        = in_valid_reg;
    assign step.enable_press = enable_press_reg;
    assign step.mode_press   = mode_press_reg;

    pts_seq #(
        .TIME_BITS (TIME_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .step_stall     (step_stall),
        .high_base_time (high_base_time),
        .high_step_time (high_step_time),
        .low_time       (low_time),
        .pulse_count    (pulse_count),
        .gap_time       (gap_time),
        .sync_time      (sync_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .wave_level     (wave_level),
        .sync_level     (sync_level),
        .mode_flag      (mode_flag)
    );

endmodule

@@ rtl/core/pts_cfg_regs.sv @@
module pts_cfg_regs
    import pts_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [TIME_BITS-1:0]     high_base_time,
    output logic [STEP_BITS-1:0]     high_step_time,
    output logic [TIME_BITS-1:0]     low_time,
    output logic [PULSE_BITS-1:0]    pulse_count,
    output logic [TIME_BITS-1:0]     gap_time,
    output logic [TIME_BITS-1:0]     sync_time
);

    logic [TIME_BITS-1:0]  high_base_reg;
    logic [STEP_BITS-1:0]  high_step_reg;
    logic [TIME_BITS-1:0]  low_reg;
    logic [PULSE_BITS-1:0] pulse_count_reg;
    logic [TIME_BITS-1:0]  gap_reg;
    logic [TIME_BITS-1:0]  sync_reg;
    reg_index_t            reg_sel;
    logic                  wr_en;

    assign reg_sel = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_base_reg   <= TIME_BITS'(HIGH_BASE_RESET);
            high_step_reg   <= STEP_BITS'(HIGH_STEP_RESET);
            low_reg         <= TIME_BITS'(LOW_RESET);
            pulse_count_reg <= PULSE_BITS'(PULSE_COUNT_RESET);
            gap_reg         <= TIME_BITS'(GAP_RESET);
            sync_reg        <= TIME_BITS'(SYNC_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_HIGH_BASE:   high_base_reg   <= pwdata[TIME_BITS-1:0];
                REG_HIGH_STEP:   high_step_reg   <= pwdata[STEP_BITS-1:0];
                REG_LOW:         low_reg         <= pwdata[TIME_BITS-1:0];
                REG_PULSE_COUNT: pulse_count_reg <= pwdata[PULSE_BITS-1:0];
                REG_GAP:         gap_reg         <= pwdata[TIME_BITS-1:0];
                REG_SYNC:        sync_reg        <= pwdata[TIME_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_HIGH_BASE:   prdata = APB_DATA_BITS'(high_base_reg);
            REG_HIGH_STEP:   prdata = APB_DATA_BITS'(high_step_reg);
            REG_LOW:         prdata = APB_DATA_BITS'(low_reg);
            REG_PULSE_COUNT: prdata = APB_DATA_BITS'(pulse_count_reg);
            REG_GAP:         prdata = APB_DATA_BITS'(gap_reg);
            REG_SYNC:        prdata = APB_DATA_BITS'(sync_reg);
            default:         prdata = '0;
        endcase
    end

    assign high_base_time = high_base_reg;
    assign high_step_time = high_step_reg;
    assign low_time       = low_reg;
    assign pulse_count    = pulse_count_reg;
    assign gap_time       = gap_reg;
    assign sync_time      = sync_reg;

endmodule

@@ rtl/core/pts_seq.sv @@
module pts_seq
    import pts_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  step_t                 step,
    output logic                  step_stall,
    input  logic [TIME_BITS-1:0]  high_base_time,
    input  logic [STEP_BITS-1:0]  high_step_time,
    input  logic [TIME_BITS-1:0]  low_time,
    input  logic [PULSE_BITS-1:0] pulse_count,
    input  logic [TIME_BITS-1:0]  gap_time,
    input  logic [TIME_BITS-1:0]  sync_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  wave_level,
    output logic                  sync_level,
    output logic                  mode_flag
);

`include "pulse_train_sync_generator_assert.svh"

    localparam int COUNT_BITS = TIME_BITS + 4;
    localparam int PROD_BITS  = PULSE_BITS + STEP_BITS;
    localparam int SUM_BITS   = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 1;
    localparam int EXT_BITS   = (SUM_BITS > COUNT_BITS) ? SUM_BITS : COUNT_BITS + 1;
    localparam logic [EXT_BITS-1:0] COUNT_MAX_EXT = EXT_BITS'({COUNT_BITS{1'b1}});

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_GAP,
        PH_SYNC
    } phase_t;

    phase_t                phase_reg, phase_next, cur_phase;
    logic [COUNT_BITS-1:0] counter_reg, counter_next, cur_count, count_left;
    logic [PULSE_BITS-1:0] index_reg, index_next, index_inc, hl_index, count_eff;
    logic                  enable_reg, enable_next;
    logic                  alt_reg, alt_next;
    logic                  out_valid_reg;
    logic                  wave_reg, wave_next;
    logic                  sync_reg, sync_next;
    logic                  mode_reg;
    logic [PROD_BITS-1:0]  hl_prod;
    logic [EXT_BITS-1:0]   hl_sum;
    logic [COUNT_BITS-1:0] hl_sat, hl_len;
    logic                  start;
    logic                  take;

    function automatic logic [COUNT_BITS-1:0] least_one(input logic [TIME_BITS-1:0] d);
        return (d == '0) ? COUNT_BITS'(1) : COUNT_BITS'(d);
    endfunction

    assign step_stall = out_valid_reg && out_stall;
    assign take       = step.valid && !step_stall;

    assign index_inc = index_reg + PULSE_BITS'(1);
    assign hl_index  = (phase_reg == PH_LOW) ? index_inc : '0;
    assign hl_prod   = PROD_BITS'(hl_index) * PROD_BITS'(high_step_time);
    assign hl_sum    = EXT_BITS'(high_base_time) + EXT_BITS'(hl_prod);
    assign hl_sat    = (hl_sum > COUNT_MAX_EXT) ? '1 : hl_sum[COUNT_BITS-1:0];
    assign hl_len    = (hl_sat == '0) ? COUNT_BITS'(1) : hl_sat;
    assign count_eff = (pulse_count == '0) ? PULSE_BITS'(1) : pulse_count;

    always_comb
    begin
        enable_next  = enable_reg ^ step.enable_press;
        alt_next     = alt_reg ^ step.mode_press;
        start        = (phase_reg == PH_IDLE) && enable_next;
        cur_phase    = start ? PH_HIGH : phase_reg;
        cur_count    = start ? hl_len : counter_reg;
        count_left   = (cur_count != '0) ? cur_count - COUNT_BITS'(1) : '0;
        phase_next   = phase_reg;
        counter_next = counter_reg;
        index_next   = index_reg;
        wave_next    = 1'b0;
        sync_next    = 1'b0;
        if (cur_phase != PH_IDLE)
        begin
            wave_next    = (cur_phase == PH_HIGH);
            sync_next    = (cur_phase == PH_SYNC);
            phase_next   = cur_phase;
            counter_next = count_left;
            index_next   = start ? '0 : index_reg;
            if (count_left == '0)
            begin
                unique case (cur_phase)
                    PH_HIGH:
                    begin
                        phase_next   = PH_LOW;
                        counter_next = least_one(low_time);
                    end
                    PH_LOW:
                    begin
                        index_next = index_inc;
                        if ((index_inc < count_eff) && (index_inc != '0))
                        begin
                            phase_next   = PH_HIGH;
                            counter_next = hl_len;
                        end
                        else
                        begin
                            phase_next   = PH_GAP;
                            counter_next = least_one(gap_time);
                        end
                    end
                    PH_GAP:
                    begin
                        phase_next   = PH_SYNC;
                        counter_next = least_one(sync_time);
                    end
                    default:
                    begin
                        phase_next   = PH_IDLE;
                        counter_next = '0;
                        index_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            counter_reg   <= '0;
            index_reg     <= '0;
            enable_reg    <= 1'b0;
            alt_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            wave_reg      <= 1'b0;
            sync_reg      <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            counter_reg   <= counter_next;
            index_reg     <= index_next;
            enable_reg    <= enable_next;
            alt_reg       <= alt_next;
            out_valid_reg <= 1'b1;
            wave_reg      <= wave_next;
            sync_reg      <= sync_next;
            mode_reg      <= alt_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign wave_level = wave_reg;
    assign sync_level = sync_reg;
    assign mode_flag  = mode_reg;

    `PTS_ASSERT_NOW(a_busy_count, phase_reg != PH_IDLE, counter_reg != '0,
        "active phase with empty tick counter")
    `PTS_ASSERT_NOW(a_idle_clear, phase_reg == PH_IDLE, (counter_reg == '0) && (index_reg == '0),
        "idle phase with stale counter or pulse index")
    `PTS_ASSERT_NOW(a_levels_excl, out_valid_reg, !(wave_reg && sync_reg),
        "wave and sync high in the same tick")
    `PTS_ASSERT_NEXT(a_take_result, take, out_valid_reg,
        "request taken without a result")

endmodule

@@ sim/pulse_train_checker.sv @@
module pulse_train_checker
    import pts_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic                     enable_press,
    input  logic                     mode_press,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     wave_level,
    input  logic                     sync_level,
    input  logic                     mode_flag,
    output int                       mismatches,
    output int                       outstanding,
    output int                       ticks_checked,
    output int                       frames_begun,
    output int                       syncs_finished
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_W = TIME_BITS + 4;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_GAP,
        SEQ_SYNC
    } seq_phase_t;

    typedef struct packed {
        logic wave;
        logic sync;
        logic mode;
    } levels_t;

    logic [TIME_BITS-1:0]  base_ticks;
    logic [STEP_BITS-1:0]  step_ticks;
    logic [TIME_BITS-1:0]  low_ticks;
    logic [PULSE_BITS-1:0] pulses_per_frame;
    logic [TIME_BITS-1:0]  gap_ticks;
    logic [TIME_BITS-1:0]  sync_ticks;

    logic                  gen_enabled;
    logic                  alt_mode;
    seq_phase_t            seq;
    logic [COUNT_W-1:0]    ticks_left;
    logic [PULSE_BITS-1:0] pulse_no;

    levels_t expected_levels[$];

    function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] d);
        return (d == '0) ? COUNT_W'(1) : d;
    endfunction

    function automatic logic [COUNT_W-1:0] high_ticks(input logic [PULSE_BITS-1:0] idx);
        logic [63:0] len;
        len = 64'(base_ticks) + 64'(idx) * 64'(step_ticks);
        if (len > 64'(COUNT_TOP))
            len = 64'(COUNT_TOP);
        return at_least_one(COUNT_W'(len));
    endfunction

    task automatic predict_tick(input logic en_press, input logic md_press);
        levels_t lv;
        logic [PULSE_BITS-1:0] frame_len;
        lv = '0;
        frame_len = (pulses_per_frame == '0) ? PULSE_BITS'(1) : pulses_per_frame;
        if (en_press)
            gen_enabled = !gen_enabled;
        if (md_press)
            alt_mode = !alt_mode;

        if (seq == SEQ_IDLE && gen_enabled)
        begin
            pulse_no = '0;
            seq = SEQ_HIGH;
            ticks_left = high_ticks('0);
            frames_begun++;
        end

        if (seq != SEQ_IDLE)
        begin
            lv.wave = (seq == SEQ_HIGH);
            lv.sync = (seq == SEQ_SYNC);
            if (ticks_left != '0)
                ticks_left = ticks_left - COUNT_W'(1);
            if (ticks_left == '0)
            begin
                case (seq)
                    SEQ_HIGH:
                    begin
                        seq = SEQ_LOW;
                        ticks_left = at_least_one(COUNT_W'(low_ticks));
                    end
                    SEQ_LOW:
                    begin
                        pulse_no = pulse_no + PULSE_BITS'(1);
                        if (pulse_no != '0 && pulse_no < frame_len)
                        begin
                            seq = SEQ_HIGH;
                            ticks_left = high_ticks(pulse_no);
                        end
                        else
                        begin
                            seq = SEQ_GAP;
                            ticks_left = at_least_one(COUNT_W'(gap_ticks));
                        end
                    end
                    SEQ_GAP:
                    begin
                        seq = SEQ_SYNC;
                        ticks_left = at_least_one(COUNT_W'(sync_ticks));
                    end
                    default:
                    begin
                        seq = SEQ_IDLE;
                        ticks_left = '0;
                        pulse_no = '0;
                        syncs_finished++;
                    end
                endcase
            end
        end

        lv.mode = alt_mode;
        expected_levels.push_back(lv);
    endtask

    task automatic report_field(input string field, input logic want, input logic got);
        if (want !== got)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t ns: %s expected %b, got %b", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        levels_t want;
        if (!rst_n)
        begin
            base_ticks       = TIME_BITS'(HIGH_BASE_RESET);
            step_ticks       = STEP_BITS'(HIGH_STEP_RESET);
            low_ticks        = TIME_BITS'(LOW_RESET);
            pulses_per_frame = PULSE_BITS'(PULSE_COUNT_RESET);
            gap_ticks        = TIME_BITS'(GAP_RESET);
            sync_ticks       = TIME_BITS'(SYNC_RESET);
            gen_enabled      = 1'b0;
            alt_mode         = 1'b0;
            seq              = SEQ_IDLE;
            ticks_left       = '0;
            pulse_no         = '0;
            expected_levels.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[APB_ADDR_BITS-1:2]))
                    REG_HIGH_BASE:   base_ticks       = pwdata[TIME_BITS-1:0];
                    REG_HIGH_STEP:   step_ticks       = pwdata[STEP_BITS-1:0];
                    REG_LOW:         low_ticks        = pwdata[TIME_BITS-1:0];
                    REG_PULSE_COUNT: pulses_per_frame = pwdata[PULSE_BITS-1:0];
                    REG_GAP:         gap_ticks        = pwdata[TIME_BITS-1:0];
                    REG_SYNC:        sync_ticks       = pwdata[TIME_BITS-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t ns: result with no request waiting, expected none, got %b%b%b",
                                 $time, wave_level, sync_level, mode_flag);
                    mismatches++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    ticks_checked++;
                    report_field("wave_level", want.wave, wave_level);
                    report_field("sync_level", want.sync, sync_level);
                    report_field("mode_flag", want.mode, mode_flag);
                end
            end

            if (in_valid && !in_stall)
                predict_tick(enable_press, mode_press);

            outstanding <= expected_levels.size();
        end
    end

endmodule

@@ sim/pulse_train_sync_generator_test.sv @@
module pulse_train_sync_generator_test
    import pts_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES    = 8;
    localparam int TICKS_PER_PHASE  = 65;
    localparam int FINAL_TICKS      = 30;
    localparam int STEADY_PHASE     = 1;
    localparam int LONG_COUNT_PHASE = 2;
    localparam int PRESSURE_PHASE   = 4;
    localparam int HOLD_CYCLES      = 80;
    localparam int SETTLE_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TIME_MAX         = (1 << TIME_BITS_DEFAULT) - 1;
    localparam int STEP_MAX         = (1 << STEP_BITS) - 1;
    localparam int PULSE_MAX        = (1 << PULSE_BITS) - 1;

    // enable press in the upper bit, mode press in the lower
    localparam int OPENING_TICKS = 20;
    localparam logic [2*OPENING_TICKS-1:0] OPENING_PRESSES = {
        2'b00, 2'b01, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00,
        2'b00, 2'b00, 2'b10, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_stall;
    logic                     enable_press;
    logic                     mode_press;
    logic                     out_valid;
    logic                     out_stall;
    logic                     wave_level;
    logic                     sync_level;
    logic                     mode_flag;

    int mismatches;
    int outstanding;
    int ticks_checked;
    int frames_begun;
    int syncs_finished;

    logic steady;
    int   hold_asked;
    int   holds_done;
    int   settings_used;
    int   quiet_cycles;

    pulse_train_sync_generator dut (.*);

    pulse_train_checker #(.TIME_BITS(TIME_BITS_DEFAULT)) checker_i (.*);

    always #5 clk = ~clk;

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    task automatic send_tick(input logic en, input logic md);
        int gap;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        enable_press <= en;
        mode_press   <= md;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_timing_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_BITS'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input logic [31:0] base_v, input logic [31:0] step_v,
                                  input logic [31:0] low_v, input logic [31:0] count_v,
                                  input logic [31:0] gap_v, input logic [31:0] sync_v);
        write_timing_reg(REG_HIGH_BASE, base_v);
        write_timing_reg(REG_HIGH_STEP, step_v);
        write_timing_reg(REG_LOW, low_v);
        write_timing_reg(REG_PULSE_COUNT, count_v);
        write_timing_reg(REG_GAP, gap_v);
        write_timing_reg(REG_SYNC, sync_v);
        settings_used++;
    endtask

    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && hold_asked != holds_done)
            begin
                // hold the results long enough for the request side to back up
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rst_n && !steady && $urandom_range(0, 4) == 0)
            begin
                n = pick_gap();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d results outstanding",
                     quiet_cycles, outstanding);
            $display("pulse_train_sync_generator_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [31:0] base_v;
        logic [31:0] step_v;
        logic [31:0] low_v;
        logic [31:0] count_v;
        logic [31:0] gap_v;
        logic [31:0] sync_v;
        logic [1:0]  press;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        enable_press  = 1'b0;
        mode_press    = 1'b0;
        steady        = 1'b0;
        hold_asked    = 0;
        settings_used = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all durations and the pulse count at zero: every phase lasts one tick
        program_timing(0, 0, 0, 0, 0, 0);
        for (int i = 0; i < OPENING_TICKS; i++)
        begin
            press = OPENING_PRESSES[2*(OPENING_TICKS-1-i) +: 2];
            send_tick(press[1], press[0]);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            if (p == LONG_COUNT_PHASE)
            begin
                base_v  = $urandom_range(0, 1);
                step_v  = 0;
                low_v   = $urandom_range(0, 1);
                count_v = PULSE_MAX;
                gap_v   = 1;
                sync_v  = 1;
            end
            else
            begin
                base_v  = $urandom_range(0, 6);
                step_v  = $urandom_range(0, 3);
                low_v   = $urandom_range(0, 5);
                count_v = $urandom_range(0, 6);
                gap_v   = $urandom_range(0, 8);
                sync_v  = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0)
                    base_v = $urandom_range(20, 60);
                if ($urandom_range(0, 3) == 0)
                    gap_v = $urandom_range(20, 60);
            end
            program_timing(base_v, step_v, low_v, count_v, gap_v, sync_v);
            steady <= (p == STEADY_PHASE || p == PRESSURE_PHASE);
            if (p == PRESSURE_PHASE)
                hold_asked <= hold_asked + 1;
            repeat (TICKS_PER_PHASE)
                send_tick($urandom_range(0, 24) == 0, $urandom_range(0, 3) == 0);
        end

        wait_drained();
        steady <= 1'b0;
        program_timing(TIME_MAX, STEP_MAX, TIME_MAX, PULSE_MAX, TIME_MAX, TIME_MAX);
        repeat (FINAL_TICKS)
            send_tick($urandom_range(0, 9) == 0, $urandom_range(0, 1) == 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d ticks over %0d timing settings, all-zero to all-maximum.",
                 ticks_checked, settings_used);
        $display("Frames begun %0d, sync pulses finished %0d, one long output hold-off.",
                 frames_begun, syncs_finished);
        if (mismatches == 0 && outstanding == 0)
            $display("pulse_train_sync_generator_test: PASS");
        else
            $display("pulse_train_sync_generator_test: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_cfg_regs.sv
rtl/core/pts_seq.sv
rtl/core/pulse_train_sync_generator.sv
sim/pulse_train_checker.sv
sim/pulse_train_sync_generator_test.sv
